// ===== rtl/kpi_pkg.sv =====
package kpi_pkg;

	// register file and keyframe layout
	localparam int REG_COUNT = 4;
	localparam int KEY_COUNT = 4;
	localparam int SEG_COUNT = KEY_COUNT - 1;
	localparam int KEY_W     = 48;
	localparam int DATA_W    = 64;
	localparam int ADDR_LSB  = 3;
	localparam int IDX_W     = $clog2(REG_COUNT);
	localparam int ADDR_W    = IDX_W + ADDR_LSB;

	// field widths
	localparam int FRAME_W = 16;
	localparam int COORD_W = 16;

	// weight and divider shape
	localparam int WEIGHT_BITS        = 8;
	localparam int DIV_BITS_PER_STAGE = 2;
	localparam int DIV_STAGES         = WEIGHT_BITS / DIV_BITS_PER_STAGE;

	// select stage, divider stages, multiply stage, output register
	localparam int PIPE_DEPTH = DIV_STAGES + 3;
	localparam int OCC_W      = $clog2(PIPE_DEPTH + 1);

	typedef logic [FRAME_W-1:0]        frame_t;
	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic [WEIGHT_BITS-1:0]    weight_t;

	// what the selected segment asks for
	typedef enum logic [1:0] {
		MODE_INTERP,
		MODE_KEY,
		MODE_PAST
	} mode_t;

	// segment end points; the b side also carries an exact or last keyframe
	typedef struct packed {
		mode_t  mode;
		coord_t ax;
		coord_t ay;
		coord_t bx;
		coord_t by;
	} seg_t;

	typedef struct packed {
		frame_t lcl;
		frame_t span;
		seg_t   seg;
	} div_req_t;

	typedef struct packed {
		weight_t t;
		seg_t    seg;
	} div_rsp_t;

endpackage

// ===== rtl/kpi_if.sv =====
interface kpi_frame_if import kpi_pkg::*; ();
	logic   valid;
	logic   ready;
	frame_t frame_number;

	modport source (output valid, output frame_number, input ready);
	modport sink (input valid, input frame_number, output ready);
endinterface

interface kpi_pos_if import kpi_pkg::*; ();
	logic   valid;
	logic   ready;
	coord_t pos_x;
	coord_t pos_y;
	logic   past_end;

	modport source (output valid, output pos_x, output pos_y, output past_end, input ready);
	modport sink (input valid, input pos_x, input pos_y, input past_end, output ready);
endinterface

// ===== rtl/kpi_div_pipe.sv =====
module kpi_div_pipe import kpi_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  div_req_t req,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	output div_rsp_t rsp
);

	typedef struct packed {
		frame_t  rem;
		frame_t  span;
		weight_t q;
		seg_t    seg;
	} div_stage_t;

	// restoring division steps, a few quotient bits per stage
	function automatic div_stage_t div_iter(div_stage_t s);
		div_stage_t         o;
		logic [FRAME_W:0]   r2;
		logic               qb;
		o = s;
		for (int j = 0; j < DIV_BITS_PER_STAGE; j++) begin
			r2 = {o.rem, 1'b0};
			if (r2 >= {1'b0, o.span}) begin
				r2 = r2 - {1'b0, o.span};
				qb = 1'b1;
			end else begin
				qb = 1'b0;
			end
			o.rem = r2[FRAME_W-1:0];
			o.q   = {o.q[WEIGHT_BITS-2:0], qb};
		end
		return o;
	endfunction

	div_stage_t div_s [DIV_STAGES];
	div_stage_t step_in [DIV_STAGES];
	logic       valid_s [DIV_STAGES];
	logic       valid_in [DIV_STAGES];
	logic       en [DIV_STAGES+1];

	// stage inputs
	always_comb begin
		step_in[0]  = '{rem: req.lcl, span: req.span, q: '0, seg: req.seg};
		valid_in[0] = req_valid;
		for (int k = 1; k < DIV_STAGES; k++) begin
			step_in[k]  = div_s[k-1];
			valid_in[k] = valid_s[k-1];
		end
	end

	// per-stage enables: a stage moves when empty or when its successor moves
	always_comb begin
		en[DIV_STAGES] = rsp_ready;
		for (int k = DIV_STAGES - 1; k >= 0; k--) begin
			en[k] = !valid_s[k] || en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DIV_STAGES; k++) begin
				valid_s[k] <= 1'b0;
			end
		end else begin
			for (int k = 0; k < DIV_STAGES; k++) begin
				if (en[k]) begin
					valid_s[k] <= valid_in[k];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < DIV_STAGES; k++) begin
			if (en[k]) begin
				div_s[k] <= div_iter(step_in[k]);
			end
		end
	end

	assign req_ready = en[0];
	assign rsp_valid = valid_s[DIV_STAGES-1];
	assign rsp       = '{t: div_s[DIV_STAGES-1].q, seg: div_s[DIV_STAGES-1].seg};

endmodule

// ===== rtl/keyframe_position_interpolator.sv =====
// a frame passes the select, divider, multiply and output registers to pos_out
// one frame per cycle unless pos_out stalls, which holds the pipeline without loss
// the weight divider runs 2 quotient bits per stage over 4 stages
// reset (arst_n low, asynchronous) clears all keyframe registers and pipeline valids
module keyframe_position_interpolator import kpi_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	kpi_frame_if.sink         frame_in,
	kpi_pos_if.source         pos_out
);

	function automatic frame_t key_frame(logic [KEY_W-1:0] w);
		return w[47:32];
	endfunction

	function automatic coord_t key_x(logic [KEY_W-1:0] w);
		return w[31:16];
	endfunction

	function automatic coord_t key_y(logic [KEY_W-1:0] w);
		return w[15:0];
	endfunction

	logic [KEY_W-1:0] key_q [REG_COUNT];
	logic [IDX_W-1:0] reg_idx;

	// apb register file
	assign reg_idx = paddr[ADDR_W-1:ADDR_LSB];
	assign pready  = 1'b1;
	assign prdata  = {{(DATA_W-KEY_W){1'b0}}, key_q[reg_idx]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < REG_COUNT; i++) begin
				key_q[i] <= '0;
			end
		end else if (psel && penable && pwrite && pready) begin
			key_q[reg_idx] <= pwdata[KEY_W-1:0];
		end
	end

	// stage 1: pick the first matching segment
	div_req_t sel_req;
	frame_t   f0;
	frame_t   f1;
	frame_t   frm;

	always_comb begin
		frm         = frame_in.frame_number;
		f0          = '0;
		f1          = '0;
		sel_req     = '0;
		sel_req.seg = '{mode: MODE_PAST, ax: '0, ay: '0,
			bx: key_x(key_q[KEY_COUNT-1]), by: key_y(key_q[KEY_COUNT-1])};
		// walk backwards so the lowest matching segment wins
		for (int s = SEG_COUNT - 1; s >= 0; s--) begin
			f0 = key_frame(key_q[s]);
			f1 = key_frame(key_q[s+1]);
			if (frm == f1) begin
				sel_req.lcl = '0;
				sel_req.span = '0;
				sel_req.seg = '{mode: MODE_KEY, ax: '0, ay: '0,
					bx: key_x(key_q[s+1]), by: key_y(key_q[s+1])};
			end else if (f0 <= frm && frm < f1) begin
				sel_req.lcl = frm - f0;
				sel_req.span = f1 - f0;
				sel_req.seg = '{mode: MODE_INTERP,
					ax: key_x(key_q[s]), ay: key_y(key_q[s]),
					bx: key_x(key_q[s+1]), by: key_y(key_q[s+1])};
			end
		end
	end

	logic     v_s1;
	div_req_t req_s1;
	logic     en1;
	logic     div_ready;
	logic     div_valid;
	div_rsp_t div_rsp;
	logic     v_s6;
	logic     en6;
	logic     v_s7;
	logic     en7;

	// backpressure chain from the output register
	assign en7            = !v_s7 || pos_out.ready;
	assign en6            = !v_s6 || en7;
	assign en1            = !v_s1 || div_ready;
	assign frame_in.ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en1) begin
			v_s1 <= frame_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			req_s1 <= sel_req;
		end
	end

	// stages 2 to 5: weight t = (local << 8) / span
	kpi_div_pipe u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (v_s1),
		.req_ready (div_ready),
		.req       (req_s1),
		.rsp_valid (div_valid),
		.rsp_ready (en6),
		.rsp       (div_rsp)
	);

	// stage 6: (b - a) * t
	localparam int PROD_W = COORD_W + WEIGHT_BITS + 2;

	logic signed [COORD_W:0]   diff_x;
	logic signed [COORD_W:0]   diff_y;
	logic signed [PROD_W-1:0]  prod_x_s6;
	logic signed [PROD_W-1:0]  prod_y_s6;
	seg_t                      seg_s6;

	assign diff_x = {div_rsp.seg.bx[COORD_W-1], div_rsp.seg.bx}
		- {div_rsp.seg.ax[COORD_W-1], div_rsp.seg.ax};
	assign diff_y = {div_rsp.seg.by[COORD_W-1], div_rsp.seg.by}
		- {div_rsp.seg.ay[COORD_W-1], div_rsp.seg.ay};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en6) begin
			v_s6 <= div_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en6) begin
			prod_x_s6 <= diff_x * $signed({1'b0, div_rsp.t});
			prod_y_s6 <= diff_y * $signed({1'b0, div_rsp.t});
			seg_s6    <= div_rsp.seg;
		end
	end

	// stage 7: floor shift, add, wrap and pick the result
	logic signed [PROD_W-1:0] sh_x;
	logic signed [PROD_W-1:0] sh_y;
	coord_t                   lerp_x;
	coord_t                   lerp_y;
	coord_t                   pos_x_s7;
	coord_t                   pos_y_s7;
	logic                     past_end_s7;

	assign sh_x   = prod_x_s6 >>> WEIGHT_BITS;
	assign sh_y   = prod_y_s6 >>> WEIGHT_BITS;
	assign lerp_x = seg_s6.ax + sh_x[COORD_W-1:0];
	assign lerp_y = seg_s6.ay + sh_y[COORD_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (en7) begin
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en7) begin
			pos_x_s7    <= (seg_s6.mode == MODE_INTERP) ? lerp_x : seg_s6.bx;
			pos_y_s7    <= (seg_s6.mode == MODE_INTERP) ? lerp_y : seg_s6.by;
			past_end_s7 <= (seg_s6.mode == MODE_PAST);
		end
	end

	assign pos_out.valid    = v_s7;
	assign pos_out.pos_x    = pos_x_s7;
	assign pos_out.pos_y    = pos_y_s7;
	assign pos_out.past_end = past_end_s7;

endmodule

// ===== rtl/kpi_checker.sv =====
module kpi_checker import kpi_pkg::*; (
	input logic   clk,
	input logic   arst_n,
	input logic   in_valid,
	input logic   in_ready,
	input logic   out_valid,
	input logic   out_ready,
	input coord_t pos_x,
	input coord_t pos_y,
	input logic   past_end
);

	logic [OCC_W-1:0] occ_q;
	logic             acc_in;
	logic             acc_out;

	assign acc_in  = in_valid && in_ready;
	assign acc_out = out_valid && out_ready;

	// transactions inside the block
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else begin
			occ_q <= occ_q + OCC_W'(acc_in) - OCC_W'(acc_out);
		end
	end

	// a stalled result holds its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pos_x) && $stable(pos_y)
			&& $stable(past_end))
		else $error("result changed while stalled");

	// input only stalls behind a full, stalled output
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled with output free");

	// never more transactions in flight than pipeline stages
	a_occ: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OCC_W'(PIPE_DEPTH))
		else $error("pipeline overfilled");

	// no result without an accepted frame
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q == '0 |-> !out_valid)
		else $error("result with nothing in flight");

endmodule

bind keyframe_position_interpolator kpi_checker u_kpi_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (frame_in.valid),
	.in_ready  (frame_in.ready),
	.out_valid (pos_out.valid),
	.out_ready (pos_out.ready),
	.pos_x     (pos_out.pos_x),
	.pos_y     (pos_out.pos_y),
	.past_end  (pos_out.past_end)
);
